// ===== rtl/cpu_bit_rotate_flag_unit_core_assert.svh =====
// Assertion macros used by the bit/flag unit checker.
`ifndef CPU_BIT_ROTATE_FLAG_UNIT_CORE_ASSERT_SVH
`define CPU_BIT_ROTATE_FLAG_UNIT_CORE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define CBRF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define CBRF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cbrf_pkg.sv =====
// Types, opcode codes and constants of the bit/rotate/flag unit.
`timescale 1ns / 1ps

package cbrf_pkg;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // unprefixed opcodes
  localparam logic [7:0] OP_RLCA = 8'h07;
  localparam logic [7:0] OP_RRCA = 8'h0F;
  localparam logic [7:0] OP_RLA  = 8'h17;
  localparam logic [7:0] OP_RRA  = 8'h1F;
  localparam logic [7:0] OP_DAA  = 8'h27;
  localparam logic [7:0] OP_CPL  = 8'h2F;
  localparam logic [7:0] OP_SCF  = 8'h37;
  localparam logic [7:0] OP_CCF  = 8'h3F;

  // INC r / DEC r: 00rrr10d
  localparam logic [7:0] INCDEC_MASK  = 8'hC6;
  localparam logic [7:0] INCDEC_MATCH = 8'h04;

  // DAA adjustments
  localparam logic [7:0] DAA_ADJ_HI  = 8'h60;
  localparam logic [7:0] DAA_ADJ_LO  = 8'h06;
  localparam logic [7:0] DAA_MAX_BCD = 8'h99;
  localparam logic [3:0] DAA_MAX_NIB = 4'h9;

  // CB opcode groups (bits 7:6)
  typedef enum logic [1:0] {
    CB_GRP_ROT = 2'd0,
    CB_GRP_BIT = 2'd1,
    CB_GRP_RES = 2'd2,
    CB_GRP_SET = 2'd3
  } cb_grp_t;

  // CB rotate/shift selectors (bits 5:3 in group 0)
  typedef enum logic [2:0] {
    CB_RLC  = 3'd0,
    CB_RRC  = 3'd1,
    CB_RL   = 3'd2,
    CB_RR   = 3'd3,
    CB_SLA  = 3'd4,
    CB_SRA  = 3'd5,
    CB_SWAP = 3'd6,
    CB_SRL  = 3'd7
  } cb_rot_t;

  typedef struct packed {
    logic       prefixed;
    logic [7:0] opcode;
    logic [7:0] operand;
    logic [3:0] flags_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       write_back;
    logic       illegal;
  } out_item_t;

endpackage

// ===== rtl/cbrf_in_if.sv =====
// Valid/ready channel carrying one operation request.
`timescale 1ns / 1ps

interface cbrf_in_if;
  logic               valid;
  logic               ready;
  cbrf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cbrf_out_if.sv =====
// Valid/ready channel carrying one operation result.
`timescale 1ns / 1ps

interface cbrf_out_if;
  logic                valid;
  logic                ready;
  cbrf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cbrf_exec.sv =====
// Combinational decode and execute of one bit/rotate/flag operation.
`timescale 1ns / 1ps

module cbrf_exec (
  input  cbrf_pkg::in_item_t  item,
  output cbrf_pkg::out_item_t res
);

  always_comb begin
    logic [7:0]        v;
    logic [7:0]        r;
    logic [7:0]        op;
    logic              z, n, h, c, wb, ill, dec;
    logic [2:0]        b;
    cbrf_pkg::cb_grp_t grp;
    cbrf_pkg::cb_rot_t rot;

    op  = item.opcode;
    v   = item.operand;
    z   = item.flags_in[cbrf_pkg::FLAG_Z];
    n   = item.flags_in[cbrf_pkg::FLAG_N];
    h   = item.flags_in[cbrf_pkg::FLAG_H];
    c   = item.flags_in[cbrf_pkg::FLAG_C];
    r   = v;
    wb  = 1'b1;
    ill = 1'b0;
    b   = op[5:3];
    grp = cbrf_pkg::cb_grp_t'(op[7:6]);
    rot = cbrf_pkg::cb_rot_t'(op[5:3]);
    dec = op[0];

    if (item.prefixed) begin
      unique case (grp)
        cbrf_pkg::CB_GRP_ROT: begin
          unique case (rot)
            cbrf_pkg::CB_RLC:  begin r = {v[6:0], v[7]};  c = v[7]; end
            cbrf_pkg::CB_RRC:  begin r = {v[0], v[7:1]};  c = v[0]; end
            cbrf_pkg::CB_RL:   begin r = {v[6:0], c};     c = v[7]; end
            cbrf_pkg::CB_RR:   begin r = {c, v[7:1]};     c = v[0]; end
            cbrf_pkg::CB_SLA:  begin r = {v[6:0], 1'b0};  c = v[7]; end
            cbrf_pkg::CB_SRA:  begin r = {v[7], v[7:1]};  c = v[0]; end
            cbrf_pkg::CB_SWAP: begin r = {v[3:0], v[7:4]}; c = 1'b0; end
            cbrf_pkg::CB_SRL:  begin r = {1'b0, v[7:1]};  c = v[0]; end
            default:           begin r = v; end
          endcase
          z = (r == 8'h00);
          n = 1'b0;
          h = 1'b0;
        end
        cbrf_pkg::CB_GRP_BIT: begin
          z  = ~v[b];
          n  = 1'b0;
          h  = 1'b1;
          wb = 1'b0;
        end
        cbrf_pkg::CB_GRP_RES: r = v & ~(8'h01 << b);
        cbrf_pkg::CB_GRP_SET: r = v | (8'h01 << b);
        default:              r = v;
      endcase
    end else if ((op & cbrf_pkg::INCDEC_MASK) == cbrf_pkg::INCDEC_MATCH) begin
      r = dec ? (v - 8'h01) : (v + 8'h01);
      z = (r == 8'h00);
      n = dec;
      h = dec ? (r[3:0] == 4'hF) : (r[3:0] == 4'h0);
    end else begin
      unique case (op)
        cbrf_pkg::OP_RLCA: begin r = {v[6:0], v[7]}; c = v[7]; z = 1'b0; n = 1'b0; h = 1'b0; end
        cbrf_pkg::OP_RRCA: begin r = {v[0], v[7:1]}; c = v[0]; z = 1'b0; n = 1'b0; h = 1'b0; end
        cbrf_pkg::OP_RLA:  begin r = {v[6:0], c};    c = v[7]; z = 1'b0; n = 1'b0; h = 1'b0; end
        cbrf_pkg::OP_RRA:  begin r = {c, v[7:1]};    c = v[0]; z = 1'b0; n = 1'b0; h = 1'b0; end
        cbrf_pkg::OP_DAA: begin
          // N is kept; after a subtraction carry is kept too
          if (n) begin
            if (c) r = r - cbrf_pkg::DAA_ADJ_HI;
            if (h) r = r - cbrf_pkg::DAA_ADJ_LO;
          end else begin
            if (c || (v > cbrf_pkg::DAA_MAX_BCD)) begin
              r = r + cbrf_pkg::DAA_ADJ_HI;
              c = 1'b1;
            end
            if (h || (v[3:0] > cbrf_pkg::DAA_MAX_NIB)) r = r + cbrf_pkg::DAA_ADJ_LO;
          end
          z = (r == 8'h00);
          h = 1'b0;
        end
        cbrf_pkg::OP_CPL: begin r = ~v; n = 1'b1; h = 1'b1; end
        cbrf_pkg::OP_SCF: begin c = 1'b1; n = 1'b0; h = 1'b0; wb = 1'b0; end
        cbrf_pkg::OP_CCF: begin c = ~c;   n = 1'b0; h = 1'b0; wb = 1'b0; end
        default: begin
          r   = 8'h00;
          wb  = 1'b0;
          ill = 1'b1;
        end
      endcase
    end

    res.result     = r;
    res.flags_out  = {z, n, h, c};
    res.write_back = wb;
    res.illegal    = ill;
  end

endmodule

// ===== rtl/cpu_bit_rotate_flag_unit_core.sv =====
// Top level of the bit/rotate/flag execution unit: input and result registers.
`timescale 1ns / 1ps

// Bit, rotate and flag execution unit of an 8-bit CPU.
// in_ch carries one request per transfer: prefixed mark, opcode, operand byte
// and Z/N/H/C flags. out_ch returns exactly one result per request, in order:
// the new byte, the new flags, a write-back mark and an illegal-opcode mark.
// A request is first held in the input register; then the decode/execute
// logic feeds the result register, from which the result is shown. Throughput
// is one operation per cycle; in_ch.ready only drops when both registers are
// full and out_ch.ready is low.
// When the receiver stalls, the result register holds its value and the
// input register keeps one more request, so up to two requests are buffered.
// A synchronous active-low reset empties both registers; nothing else has
// state, so the unit accepts requests in the first cycle after reset.

module cpu_bit_rotate_flag_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  cbrf_in_if.sink     in_ch,
  cbrf_out_if.source  out_ch
);

  logic                s1_vld_r, s1_vld_nxt;
  cbrf_pkg::in_item_t  s1_item_r;
  logic                s2_vld_r, s2_vld_nxt;
  cbrf_pkg::out_item_t s2_item_r;
  cbrf_pkg::out_item_t exec_res;
  logic                in_xfer, out_xfer, s2_load;

  cbrf_exec u_exec (
    .item (s1_item_r),
    .res  (exec_res)
  );

  assign s2_load     = s1_vld_r && (!s2_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s2_load;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = s2_vld_r && out_ch.ready;

  assign out_ch.valid = s2_vld_r;
  assign out_ch.data  = s2_item_r;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) s1_vld_nxt = 1'b1;
    else if (s2_load) s1_vld_nxt = 1'b0;

    s2_vld_nxt = s2_vld_r;
    if (s2_load) s2_vld_nxt = 1'b1;
    else if (out_xfer) s2_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s1_item_r <= in_ch.data;
    if (s2_load) s2_item_r <= exec_res;
  end

endmodule

// ===== rtl/cbrf_checker.sv =====
// Port-level checks of the bit/rotate/flag unit, bound to the top level.
`timescale 1ns / 1ps
`include "cpu_bit_rotate_flag_unit_core_assert.svh"

module cbrf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input cbrf_pkg::out_item_t out_data
);

  `CBRF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

  `CBRF_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  `CBRF_ASSERT(a_illegal_no_wb, clk, rst_n, out_valid && out_data.illegal |-> !out_data.write_back && (out_data.result == 8'h00), "illegal result marked for write-back")

  `CBRF_ASSERT(a_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready |=> out_valid, "result not shown two cycles after transfer")

endmodule

bind cpu_bit_rotate_flag_unit_core cbrf_checker u_cbrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
